>>> hdl/lsx_pkg.sv
package lsx_pkg;

  localparam int LSX_MAX_POINTS_DEF = 256;
  localparam int LSX_IN_W           = 16;
  // 8 fraction bits plus one for the half-LSB rounding term
  localparam int LSX_FRAC_SHIFT     = 9;

  localparam logic [31:0] LSX_POS_LIM = 32'h7FFF_FFFF;
  localparam logic [31:0] LSX_NEG_LIM = 32'h8000_0000;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_DRAIN,
    ST_MSTART,
    ST_MWAIT,
    ST_NEG,
    ST_PREP,
    ST_DIV,
    ST_EMIT
  } lsx_state_t;

  // multiply steps of the fit, in issue order
  typedef enum logic [3:0] {
    OP_N_XX,
    OP_X_X,
    OP_N_XY,
    OP_X_Y,
    OP_N_L,
    OP_X_1,
    OP_D_Y,
    OP_N_DL,
    OP_N_D
  } lsx_op_t;

  typedef struct packed {
    logic start;
    logic clr;
    logic sub;
  } lsx_mac_ctl_t;

  function automatic lsx_op_t lsx_next_op(lsx_op_t op);
    lsx_op_t nxt;
    case (op)
      OP_N_XX: nxt = OP_X_X;
      OP_X_X:  nxt = OP_N_XY;
      OP_N_XY: nxt = OP_X_Y;
      OP_X_Y:  nxt = OP_N_L;
      OP_N_L:  nxt = OP_X_1;
      OP_X_1:  nxt = OP_D_Y;
      OP_D_Y:  nxt = OP_N_DL;
      OP_N_DL: nxt = OP_N_D;
      default: nxt = OP_N_XX;
    endcase
    return nxt;
  endfunction

  function automatic logic lsx_op_sub(lsx_op_t op);
    return (op inside {OP_X_X, OP_X_Y, OP_X_1});
  endfunction

  function automatic logic lsx_op_clr(lsx_op_t op);
    return (op inside {OP_N_XX, OP_N_XY, OP_N_L, OP_D_Y, OP_N_D});
  endfunction

endpackage

>>> hdl/lsx_acc.sv
module lsx_acc import lsx_pkg::*; #(
  parameter int MAX_POINTS = LSX_MAX_POINTS_DEF,
  parameter int CW         = 9,
  parameter int SW         = 25,
  parameter int PW         = 40
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pt_vld,
  input  logic signed [LSX_IN_W-1:0]  pt_x,
  input  logic signed [LSX_IN_W-1:0]  pt_y,
  input  logic                        pt_last,
  input  logic                        clr,
  output logic [CW-1:0]               count,
  output logic signed [SW-1:0]        sum_x,
  output logic signed [SW-1:0]        sum_y,
  output logic signed [PW-1:0]        sum_xy,
  output logic signed [PW-1:0]        sum_xx,
  output logic                        fit_go
);

  localparam logic [CW-1:0] MAXC = CW'(MAX_POINTS);
  localparam int PRW = 2 * LSX_IN_W;

  logic                       v1_r, last1_r, v2_r, last2_r, go_r;
  logic signed [LSX_IN_W-1:0] x1_r, y1_r, x2_r, y2_r;
  logic signed [PRW-1:0]      pxy_r, pxx_r;
  logic [CW-1:0]              cnt_r;
  logic signed [SW-1:0]       sx_r, sy_r;
  logic signed [PW-1:0]       sxy_r, sxx_r;

  // stage 1: capture, stage 2: products, stage 3: sums
  always_ff @(posedge clk) begin
    x1_r    <= pt_x;
    y1_r    <= pt_y;
    last1_r <= pt_last;
    x2_r    <= x1_r;
    y2_r    <= y1_r;
    last2_r <= last1_r;
    pxy_r   <= x1_r * y1_r;
    pxx_r   <= x1_r * x1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      go_r  <= 1'b0;
      cnt_r <= '0;
      sx_r  <= '0;
      sy_r  <= '0;
      sxy_r <= '0;
      sxx_r <= '0;
    end else begin
      v1_r <= pt_vld;
      v2_r <= v1_r;
      go_r <= v2_r & last2_r;
      if (clr) begin
        cnt_r <= '0;
        sx_r  <= '0;
        sy_r  <= '0;
        sxy_r <= '0;
        sxx_r <= '0;
      end else if (v2_r && (cnt_r < MAXC)) begin
        cnt_r <= cnt_r + CW'(1);
        sx_r  <= sx_r + {{(SW-LSX_IN_W){x2_r[LSX_IN_W-1]}}, x2_r};
        sy_r  <= sy_r + {{(SW-LSX_IN_W){y2_r[LSX_IN_W-1]}}, y2_r};
        sxy_r <= sxy_r + {{(PW-PRW){pxy_r[PRW-1]}}, pxy_r};
        sxx_r <= sxx_r + {{(PW-PRW){pxx_r[PRW-1]}}, pxx_r};
      end
    end
  end

  assign count  = cnt_r;
  assign sum_x  = sx_r;
  assign sum_y  = sy_r;
  assign sum_xy = sxy_r;
  assign sum_xx = sxx_r;
  assign fit_go = go_r;

endmodule

>>> hdl/lsx_smul.sv
module lsx_smul import lsx_pkg::*; #(
  parameter int WW = 86,
  parameter int BW = 26
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lsx_mac_ctl_t         ctl,
  input  logic signed [WW-1:0] a_in,
  input  logic signed [BW-1:0] b_in,
  output logic signed [WW-1:0] acc,
  output logic                 done
);

  // acc (+/-)= a * b, one multiplier bit per cycle, LSB first;
  // the top bit of b carries negative weight
  localparam int CNTW = $clog2(BW);
  localparam logic [CNTW-1:0] LASTC = CNTW'(BW - 1);

  logic signed [WW-1:0] a_r, acc_r;
  logic [BW-1:0]        b_r;
  logic [CNTW-1:0]      cnt_r;
  logic                 busy_r, done_r, sub_r;
  logic                 neg;
  logic [WW-1:0]        term;

  assign neg  = sub_r ^ (cnt_r == LASTC);
  assign term = b_r[0] ? (a_r ^ {WW{neg}}) : '0;

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_r <= a_in;
      b_r <= b_in;
    end else if (busy_r) begin
      a_r <= a_r <<< 1;
      b_r <= b_r >> 1;
    end
    if (ctl.start) begin
      if (ctl.clr) begin
        acc_r <= '0;
      end
    end else if (busy_r) begin
      acc_r <= acc_r + term + WW'(b_r[0] & neg);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      sub_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        sub_r  <= ctl.sub;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNTW'(1);
        if (cnt_r == LASTC) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

>>> hdl/lsx_sdiv.sv
module lsx_sdiv import lsx_pkg::*; #(
  parameter int WW = 86
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [WW-1:0] numer,
  input  logic [WW-1:0] denom,
  output logic [WW-1:0] quot,
  output logic          done
);

  // restoring division, one quotient bit per cycle, MSB first
  localparam int CNTW = $clog2(WW);
  localparam logic [CNTW-1:0] LASTC = CNTW'(WW - 1);

  logic [WW-1:0]   q_r, r_r, d_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r, done_r;
  logic [WW:0]     trial, diff;

  assign trial = {r_r, q_r[WW-1]};
  assign diff  = trial - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= numer;
      r_r <= '0;
      d_r <= denom;
    end else if (busy_r) begin
      q_r <= {q_r[WW-2:0], ~diff[WW]};
      r_r <= diff[WW] ? trial[WW-1:0] : diff[WW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNTW'(1);
        if (cnt_r == LASTC) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quot = q_r;
  assign done = done_r;

endmodule

>>> hdl/least_squares_line_extrapolate.sv
// Least-squares line through a set of points, evaluated at a programmed load.
// Throughput: one point word per cycle while a set accumulates; the set closes on tlast.
// Last word to result: nine passes of the bit-serial multiplier (BW = clog2(MAX_POINTS+1)+17),
//   then the bit-serial divider (WW = 3*clog2(MAX_POINTS+1)+59); a degenerate set stops after
//   the first two passes. No word is taken until the result is registered.
// Reset (rst_n low, synchronous): sums, count, load register and out_tvalid cleared; in_tready high.
module least_squares_line_extrapolate import lsx_pkg::*; #(
  parameter int MAX_POINTS = LSX_MAX_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] load_x, [31:16] reading_y
  input  logic        in_tlast,   // last_point
  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] fitted_value
  output logic [1:0]  out_tuser,  // [0] degenerate, [1] saturated
  // extrapolation load register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  // Widths follow from the point count bound:
  //   CW count, SW sum of x / y, PW sum of products,
  //   DW denominator D, NW slope numerator N, BW serial multiplier operand,
  //   WW wide datapath holding the scaled numerator with sign.
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int SW = CW + LSX_IN_W;
  localparam int PW = CW + 2 * LSX_IN_W - 1;
  localparam int BW = SW + 1;
  localparam int DW = 2 * CW + 31;
  localparam int NW = 2 * CW + 32;
  localparam int WW = 3 * CW + 59;

  lsx_state_t state_r, state_nxt;
  lsx_op_t    op_r, op_nxt;

  logic signed [LSX_IN_W-1:0] load_r;

  logic                 fit_go, acc_clr;
  logic [CW-1:0]        count;
  logic signed [SW-1:0] sum_x, sum_y;
  logic signed [PW-1:0] sum_xy, sum_xx;

  lsx_mac_ctl_t         mac_ctl;
  logic signed [WW-1:0] mac_a, mac_acc;
  logic signed [BW-1:0] mac_b;
  logic                 mac_done;
  logic                 acc_nonpos;

  logic signed [DW-1:0] d_r;
  logic signed [NW-1:0] n_r;
  logic signed [BW-1:0] dl_r;
  logic [WW-1:0]        numer_r;
  logic                 neg_r, degen_r;
  logic                 d_en, n_en, dl_en, numer_en;

  logic                 div_start, div_done;
  logic [WW-1:0]        div_numer, div_denom, div_q;

  logic                 out_load;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [31:0]          out_tdata_r, res_val;
  logic [1:0]           out_tuser_r;
  logic                 q_hi_nz, res_sat;

  // ---------------------------------------------------------------------------
  // Config register: always ready; only written between sets, a rule the user keeps, not enforced
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_r <= '0;
    end else if (cfg_valid) begin
      load_r <= cfg_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Point accumulation: count and exact sums, three-stage pipe
  assign in_tready = (state_r == ST_ACC);

  lsx_acc #(
    .MAX_POINTS (MAX_POINTS),
    .CW         (CW),
    .SW         (SW),
    .PW         (PW)
  ) u_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .pt_vld  (in_tvalid & in_tready),
    .pt_x    (in_tdata[15:0]),
    .pt_y    (in_tdata[31:16]),
    .pt_last (in_tlast),
    .clr     (acc_clr),
    .count   (count),
    .sum_x   (sum_x),
    .sum_y   (sum_y),
    .sum_xy  (sum_xy),
    .sum_xx  (sum_xx),
    .fit_go  (fit_go)
  );

  // ---------------------------------------------------------------------------
  // Fit, as a sequence of multiply-accumulate passes on one serial unit:
  //   D  = n*sum_xx - sum_x*sum_x        (D <= 0 means degenerate set)
  //   N  = n*sum_xy - sum_x*sum_y
  //   dl = n*L - sum_x
  //   num = D*sum_y + N*dl
  //   den = n*D
  // then value = round(256*num / den), half away from zero, via
  //   q = (512*|num| + den) / (2*den)
  always_comb begin
    case (op_r)
      OP_N_XX: begin
        mac_a = {{(WW-PW){sum_xx[PW-1]}}, sum_xx};
        mac_b = {{(BW-CW){1'b0}}, count};
      end
      OP_X_X: begin
        mac_a = {{(WW-SW){sum_x[SW-1]}}, sum_x};
        mac_b = {{(BW-SW){sum_x[SW-1]}}, sum_x};
      end
      OP_N_XY: begin
        mac_a = {{(WW-PW){sum_xy[PW-1]}}, sum_xy};
        mac_b = {{(BW-CW){1'b0}}, count};
      end
      OP_X_Y: begin
        mac_a = {{(WW-SW){sum_x[SW-1]}}, sum_x};
        mac_b = {{(BW-SW){sum_y[SW-1]}}, sum_y};
      end
      OP_N_L: begin
        mac_a = {{(WW-LSX_IN_W){load_r[LSX_IN_W-1]}}, load_r};
        mac_b = {{(BW-CW){1'b0}}, count};
      end
      OP_X_1: begin
        mac_a = {{(WW-SW){sum_x[SW-1]}}, sum_x};
        mac_b = BW'(1);
      end
      OP_D_Y: begin
        mac_a = {{(WW-DW){d_r[DW-1]}}, d_r};
        mac_b = {{(BW-SW){sum_y[SW-1]}}, sum_y};
      end
      OP_N_DL: begin
        mac_a = {{(WW-NW){n_r[NW-1]}}, n_r};
        mac_b = dl_r;
      end
      OP_N_D: begin
        mac_a = {{(WW-DW){d_r[DW-1]}}, d_r};
        mac_b = {{(BW-CW){1'b0}}, count};
      end
      default: begin
        mac_a = '0;
        mac_b = '0;
      end
    endcase
  end

  lsx_smul #(
    .WW (WW),
    .BW (BW)
  ) u_smul (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .a_in  (mac_a),
    .b_in  (mac_b),
    .acc   (mac_acc),
    .done  (mac_done)
  );

  assign acc_nonpos = mac_acc[WW-1] | (mac_acc == '0);

  // operands kept between passes
  always_ff @(posedge clk) begin
    if (d_en) begin
      d_r     <= mac_acc[DW-1:0];
      degen_r <= acc_nonpos;
    end
    if (n_en) begin
      n_r <= mac_acc[NW-1:0];
    end
    if (dl_en) begin
      dl_r <= mac_acc[BW-1:0];
    end
    if (numer_en) begin
      numer_r <= mac_acc[WW-1] ? (~mac_acc + WW'(1)) : mac_acc;
      neg_r   <= mac_acc[WW-1];
    end
  end

  // divider operands; mac_acc holds den during the load step
  assign div_numer = (numer_r << LSX_FRAC_SHIFT) + mac_acc;
  assign div_denom = mac_acc << 1;

  lsx_sdiv #(
    .WW (WW)
  ) u_sdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (div_numer),
    .denom (div_denom),
    .quot  (div_q),
    .done  (div_done)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACC;
      op_r    <= OP_N_XX;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    mac_ctl   = '0;
    d_en      = 1'b0;
    n_en      = 1'b0;
    dl_en     = 1'b0;
    numer_en  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    acc_clr   = 1'b0;
    case (state_r)
      ST_ACC: begin
        if (in_tvalid && in_tlast) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait for the last point to land in the sums
        if (fit_go) begin
          op_nxt    = OP_N_XX;
          state_nxt = ST_MSTART;
        end
      end
      ST_MSTART: begin
        mac_ctl.start = 1'b1;
        mac_ctl.clr   = lsx_op_clr(op_r);
        mac_ctl.sub   = lsx_op_sub(op_r);
        state_nxt     = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (mac_done) begin
          op_nxt    = lsx_next_op(op_r);
          state_nxt = ST_MSTART;
          case (op_r)
            OP_X_X: begin
              d_en = 1'b1;
              if (acc_nonpos) begin
                state_nxt = ST_EMIT;
              end
            end
            OP_X_Y:  n_en = 1'b1;
            OP_X_1:  dl_en = 1'b1;
            OP_N_DL: state_nxt = ST_NEG;
            OP_N_D:  state_nxt = ST_PREP;
            default: ;
          endcase
        end
      end
      ST_NEG: begin
        numer_en  = 1'b1;
        op_nxt    = OP_N_D;
        state_nxt = ST_MSTART;
      end
      ST_PREP: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // result register free: load it and start a new set
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          acc_clr   = 1'b1;
          state_nxt = ST_ACC;
        end
      end
      default: state_nxt = ST_ACC;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Rounding already folded into the division; clip to signed 32 bits
  assign q_hi_nz = |div_q[WW-1:32];
  assign res_sat = neg_r ? (q_hi_nz | (div_q[31] & (|div_q[30:0])))
                         : (q_hi_nz | div_q[31]);

  always_comb begin
    if (res_sat) begin
      res_val = neg_r ? LSX_NEG_LIM : LSX_POS_LIM;
    end else if (neg_r) begin
      res_val = ~div_q[31:0] + 32'd1;
    end else begin
      res_val = div_q[31:0];
    end
  end

  // result register: one word held until taken
  assign out_tvalid_nxt = out_load | (out_tvalid_r & ~out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= degen_r ? '0 : res_val;
      out_tuser_r <= {~degen_r & res_sat, degen_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // ---------------------------------------------------------------------------
  // Checks
  a_go_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    fit_go |-> (state_r == ST_DRAIN))
    else $error("fit start outside drain");

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == ST_EMIT))
    else $error("result word raised outside emit");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> !(out_tuser_r[0] && out_tuser_r[1]))
    else $error("degenerate and saturated together");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tuser_r[0]) |-> (out_tdata_r == '0))
    else $error("degenerate result not zero");

endmodule

>>> test/least_squares_line_extrapolate_tb.sv
`timescale 1ns / 1ps

module least_squares_line_extrapolate_tb;
  import lsx_pkg::*;

  localparam int MAX_PTS = LSX_MAX_POINTS_DEF;
  // out_tuser bit positions
  localparam int TU_DEGENERATE = 0;
  localparam int TU_SATURATED  = 1;
  // idle cycles before a load write, once the last fit is back
  localparam int LOAD_GUARD    = 8;
  // tail and drain bounds sit well above the time one fit takes
  localparam int TAIL_CYCLES   = 400;
  localparam int DRAIN_MAX     = 200000;
  localparam int IDLE_PCT      = 22;
  // point-word budget per random phase; the last set may run past it
  localparam int PHASE_WORDS   = 125;

  // one fitted result word as the block should present it
  typedef struct packed {
    logic signed [31:0] value;
    logic               degenerate;
    logic               saturated;
  } fit_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // [15:0] load_x, [31:16] reading_y
  logic        in_tlast   = 1'b0; // last_point
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [31:0] fitted_value
  logic [1:0]  out_tuser;         // [0] degenerate, [1] saturated
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data   = '0;

  // shadow of the block: load register and running sums of the open set
  logic signed [15:0] load_reg = '0;
  int                 pt_count = 0;
  longint             acc_x = 0, acc_y = 0, acc_xy = 0, acc_xx = 0;
  bit                 set_clipped = 1'b0;

  fit_t fits_due[$];

  // when set, neither side inserts idle cycles
  bit steady = 1'b0;

  int mismatches    = 0;
  int words_sent    = 0;
  int sets_sent     = 0;
  int fits_checked  = 0;
  int degen_seen    = 0;
  int sat_seen      = 0;
  int clipped_sets  = 0;

  least_squares_line_extrapolate #(
    .MAX_POINTS(MAX_PTS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // hard stop, far beyond the slowest correct run
  initial begin
    #50_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
  endtask

  // Least-squares fit of the open set, evaluated at load_reg.
  // With D = n*Sxx - Sx^2 and N = n*Sxy - Sx*Sy the line value is
  // (Sy*D + N*(n*L - Sx)) / (n*D); scaled by 256 and rounded half away from zero.
  function automatic fit_t fit_line();
    logic signed [127:0] n, sx, sy, sxy, sxx, lw, d, slope_num, dl, num, den;
    logic        [127:0] mag, q;
    fit_t r;
    n   = pt_count;
    sx  = acc_x;
    sy  = acc_y;
    sxy = acc_xy;
    sxx = acc_xx;
    lw  = load_reg;
    r   = '0;
    d   = n * sxx - sx * sx;
    if (d <= 0) begin
      // all loads equal or under two points
      r.degenerate = 1'b1;
      return r;
    end
    slope_num = n * sxy - sx * sy;
    dl        = n * lw - sx;
    num       = sy * d + slope_num * dl;
    den       = n * d;
    mag       = (num < 0) ? -num : num;
    q         = (mag * 512 + den) / (den * 2);
    if (num < 0) begin
      if (q > 128'h8000_0000) begin
        r.value     = LSX_NEG_LIM;
        r.saturated = 1'b1;
      end else begin
        r.value = -q[31:0];
      end
    end else begin
      if (q > 128'h7FFF_FFFF) begin
        r.value     = LSX_POS_LIM;
        r.saturated = 1'b1;
      end else begin
        r.value = q[31:0];
      end
    end
    return r;
  endfunction

  // shadow update for one accepted point word
  task automatic take_point(input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic last);
    if (pt_count < MAX_PTS) begin
      pt_count++;
      acc_x  += longint'(x);
      acc_y  += longint'(y);
      acc_xy += longint'(x) * longint'(y);
      acc_xx += longint'(x) * longint'(x);
    end else begin
      // block drops points past the limit
      set_clipped = 1'b1;
    end
    words_sent++;
    if (last) begin
      fits_due.push_back(fit_line());
      sets_sent++;
      if (set_clipped) clipped_sets++;
      pt_count    = 0;
      acc_x       = 0;
      acc_y       = 0;
      acc_xy      = 0;
      acc_xx      = 0;
      set_clipped = 1'b0;
    end
  endtask

  // Drive one point word and hold it until taken. Valid is left high afterwards,
  // so back-to-back words never see valid dropped and raised in one step.
  // Each cycle before the word idles with IDLE_PCT chance.
  task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic last);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    take_point(x, y, last);
  endtask

  // Load writes only go in with the block idle: stream stopped, every fit back.
  task automatic write_load(input logic signed [15:0] v);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (fits_due.size() != 0) @(posedge clk);
    repeat (LOAD_GUARD) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    load_reg = v;
  endtask

  // result side: random back-pressure, checked against the oldest pending fit
  always @(posedge clk) begin
    if (steady) out_tready <= 1'b1;
    else        out_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    fit_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (fits_due.size() == 0) begin
        flag_mismatch("result word with no fit pending", out_tdata, '0);
      end else begin
        want = fits_due.pop_front();
        fits_checked++;
        if (want.degenerate) degen_seen++;
        if (want.saturated)  sat_seen++;
        if (out_tdata !== want.value)
          flag_mismatch("fitted_value", out_tdata, want.value);
        if (out_tuser[TU_DEGENERATE] !== want.degenerate)
          flag_mismatch("degenerate", out_tuser[TU_DEGENERATE], want.degenerate);
        if (out_tuser[TU_SATURATED] !== want.saturated)
          flag_mismatch("saturated", out_tuser[TU_SATURATED], want.saturated);
      end
    end
  end

  // reset load of zero, field extremes
  task automatic test_reset_load();
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd2, 16'sd512, 1'b1);
    send_point(-16'sd32768, -16'sd32768, 1'b0);
    send_point(16'sd32767, 16'sd32767, 1'b1);
    send_point(16'sd32767, -16'sd32768, 1'b0);
    send_point(-16'sd32768, 16'sd32767, 1'b0);
    send_point(16'sd1, 16'sd3, 1'b1);
  endtask

  // lone point, equal loads, all zero
  task automatic test_degenerate();
    send_point(16'sd7, 16'sd7, 1'b1);
    send_point(16'sd5, 16'sd100, 1'b0);
    send_point(16'sd5, -16'sd200, 1'b0);
    send_point(16'sd5, 16'sd32767, 1'b1);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b1);
  endtask

  // steep lines evaluated at the load extremes clip both ways
  task automatic test_saturation();
    write_load(16'sd32767);
    send_point(16'sd0, -16'sd32768, 1'b0);
    send_point(16'sd1, 16'sd32767, 1'b1);
    write_load(-16'sd32768);
    send_point(16'sd0, -16'sd32768, 1'b0);
    send_point(16'sd1, 16'sd32767, 1'b1);
    send_point(16'sd0, 16'sd32767, 1'b0);
    send_point(16'sd1, -16'sd32768, 1'b1);
  endtask

  // exact half LSB rounds away from zero, quarter rounds to zero
  task automatic test_rounding();
    write_load(16'sd1);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd512, 16'sd1, 1'b1);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd512, -16'sd1, 1'b1);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd1024, 16'sd1, 1'b1);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd512, 16'sd3, 1'b1);
  endtask

  // sets longer than the point limit: extra points are dropped, last still fits
  task automatic test_point_limit();
    int i;
    write_load(16'sd100);
    for (i = 0; i < MAX_PTS + 14; i++)
      send_point(16'($urandom_range(0, 2000)) - 16'sd1000, 16'($urandom),
                 i == MAX_PTS + 13);
    for (i = 0; i < MAX_PTS; i++)
      send_point(16'($urandom), 16'($urandom_range(0, 400)), 1'b0);
    send_point(16'sd3, 16'sd3, 1'b1);
  endtask

  // random sets, mostly short, with a mix of load spreads
  task automatic test_random_sets(input int budget);
    int sent, size, style, base, pick, i;
    logic signed [15:0] x, y;
    sent = 0;
    while (sent < budget) begin
      pick  = $urandom_range(0, 99);
      size  = (pick < 8) ? 1 : (pick < 85) ? $urandom_range(2, 16) : $urandom_range(17, 64);
      style = $urandom_range(0, 9);
      base  = $urandom_range(0, 65535) - 32768;
      for (i = 0; i < size; i++) begin
        case (style)
          5, 6, 7: begin
            // narrow spread round a random centre
            x = 16'(base) + 16'($urandom_range(0, 31)) - 16'sd16;
            y = 16'($urandom);
          end
          8: begin
            // one load throughout
            x = 16'(base);
            y = 16'($urandom);
          end
          9: begin
            x = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            y = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
          end
          default: begin
            x = 16'($urandom);
            y = 16'($urandom);
          end
        endcase
        send_point(x, y, i == size - 1);
      end
      sent += size;
    end
  endtask

  initial begin
    int guard;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_load();
    test_degenerate();
    test_saturation();
    test_rounding();
    test_point_limit();

    // random phases across the load range; the second runs with no idling
    write_load(16'sd0);
    test_random_sets(PHASE_WORDS);
    write_load(16'sd32767);
    steady = 1'b1;
    test_random_sets(PHASE_WORDS);
    steady = 1'b0;
    write_load(-16'sd32768);
    test_random_sets(PHASE_WORDS);
    write_load(16'($urandom));
    test_random_sets(PHASE_WORDS);
    write_load(16'($urandom_range(0, 200)) - 16'sd100);
    test_random_sets(PHASE_WORDS);
    write_load(16'($urandom));
    test_random_sets(PHASE_WORDS);

    // drain, then let the block settle
    in_tvalid <= 1'b0;
    guard = 0;
    while (fits_due.size() != 0 && guard < DRAIN_MAX) begin
      @(posedge clk);
      guard++;
    end
    if (fits_due.size() != 0)
      flag_mismatch("fits never returned", fits_due.size(), '0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d point words in %0d sets, directed cases then six random load phases",
             words_sent, sets_sent);
    $display("%0d fits checked: %0d degenerate, %0d saturated, %0d sets past the point limit",
             fits_checked, degen_seen, sat_seen, clipped_sets);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/lsx_pkg.sv
hdl/lsx_acc.sv
hdl/lsx_smul.sv
hdl/lsx_sdiv.sv
hdl/least_squares_line_extrapolate.sv
test/least_squares_line_extrapolate_tb.sv
